[design/radix_digits_to_ascii_assert.svh]
// ----------------------------------------------------------------------------
// radix_digits_to_ascii assertion macros
// Property wrappers shared by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGITS_TO_ASCII_ASSERT_SVH
`define RADIX_DIGITS_TO_ASCII_ASSERT_SVH

// Same-cycle implication, off during reset
`define RDTA_ASSERT_NOW(label, clk, rst, cond, resp) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (resp)) \
    else $error("radix_digits_to_ascii: same-cycle check failed");

// Next-cycle implication, off during reset
`define RDTA_ASSERT_NEXT(label, clk, rst, cond, resp) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (resp)) \
    else $error("radix_digits_to_ascii: next-cycle check failed");

`endif

[design/rdta_pkg.sv]
// ----------------------------------------------------------------------------
// rdta_pkg
// Shared constants, types and state encodings of the radix digit converter.
// ----------------------------------------------------------------------------
package rdta_pkg;

  // Field widths
  localparam int VALUE_W = 64;
  localparam int RADIX_W = 5;
  localparam int CHARS_W = 64;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 7;
  localparam int DIGIT_W = 4;

  // Sizing
  localparam int VALUE_BITS  = 64;
  localparam int MAX_RADIX   = 16;
  localparam int STORE_DEPTH = VALUE_BITS;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  // Divider: restoring steps per cycle, cycles per digit
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD_BITS   = DIV_CYCLES * DIV_STEPS;
  localparam int CYC_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Descriptor queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

  // Reset values
  localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
  localparam logic [CHARS_W-1:0] CHARS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [CHARS_W-1:0] CHARS_HIGH_RESET = 64'h6665646362613938;

  // One digit written into the digit store (bank bit on top of the address)
  typedef struct packed {
    logic               en;
    logic [IDX_W:0]     addr;
    logic [DIGIT_W-1:0] digit;
  } store_wr_t;

  // Finished conversion handed from front to back
  typedef struct packed {
    logic               bank;
    logic [COUNT_W-1:0] count;
  } q_entry_t;

  typedef enum logic { FE_IDLE, FE_DIV } fe_state_t;
  typedef enum logic { BK_IDLE, BK_SEND } bk_state_t;

endpackage

[design/rdta_front.sv]
// ----------------------------------------------------------------------------
// rdta_front
// Accepts a value and splits it into digits, least significant first, by
// repeated division with a shared 8-step-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module rdta_front import rdta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [VALUE_W-1:0]   s_tdata,
  input  logic [RADIX_W-1:0]   radix,
  input  logic                 q_full,
  output logic                 push,
  output q_entry_t             push_entry,
  output store_wr_t            store_wr
);

  fe_state_t state, state_next;

  logic [PAD_BITS-1:0]  work;
  logic [RADIX_W-1:0]   rem;
  logic [CYC_W-1:0]     cyc;
  logic [COUNT_W-1:0]   n;
  logic                 wr_bank;

  logic [PAD_BITS-1:0]           work_next;
  logic [PAD_BITS+DIV_STEPS-1:0] work_wide;
  logic [DIV_STEPS-1:0]          q_bits;
  logic [RADIX_W-1:0]            rem_next;
  logic [COUNT_W-1:0]            count_inc;
  logic                          last_cycle;
  logic                          done;
  logic                          accept;

  // Divider slice: eight restoring steps over the top bits of work
  always_comb begin
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    r      = rem;
    q_bits = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, work[PAD_BITS-1-i]};
      if (t >= {1'b0, radix}) begin
        t = t - {1'b0, radix};
        q_bits[DIV_STEPS-1-i] = 1'b1;
      end
      r = t[RADIX_W-1:0];
    end
    rem_next = r;
  end

  // Quotient bits shift in from below as dividend bits leave the top
  assign work_wide  = {work, q_bits};
  assign work_next  = work_wide[PAD_BITS-1:0];
  assign count_inc  = n + COUNT_W'(1);
  assign last_cycle = (cyc == CYC_W'(DIV_CYCLES - 1));
  assign done       = (work_next == '0) || (count_inc == COUNT_W'(STORE_DEPTH));
  assign accept     = s_tvalid && s_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: begin
        if (accept) state_next = FE_DIV;
      end
      FE_DIV: begin
        if (last_cycle && done) state_next = FE_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_tready         = 1'b0;
    push             = 1'b0;
    store_wr.en      = 1'b0;
    store_wr.addr    = {wr_bank, n[IDX_W-1:0]};
    store_wr.digit   = rem_next[DIGIT_W-1:0];
    push_entry.bank  = wr_bank;
    push_entry.count = count_inc;
    unique case (state)
      FE_IDLE: begin
        s_tready = !q_full;
      end
      FE_DIV: begin
        store_wr.en = last_cycle;
        push        = last_cycle && done;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FE_IDLE;
      wr_bank <= 1'b0;
    end else begin
      state <= state_next;
      if (push) wr_bank <= !wr_bank;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      work <= PAD_BITS'(s_tdata[VALUE_BITS-1:0]);
      rem  <= '0;
      cyc  <= '0;
      n    <= '0;
    end else if (state == FE_DIV) begin
      work <= work_next;
      if (last_cycle) begin
        rem <= '0;
        cyc <= '0;
        n   <= count_inc;
      end else begin
        rem <= rem_next;
        cyc <= cyc + CYC_W'(1);
      end
    end
  end

endmodule

[design/rdta_queue.sv]
// ----------------------------------------------------------------------------
// rdta_queue
// Two-entry descriptor FIFO between the converter and the emitter.
// ----------------------------------------------------------------------------
module rdta_queue import rdta_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output logic     full,
  output logic     empty
);

  q_entry_t            entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   cnt;

  assign head  = entries[rd_ptr];
  assign full  = (cnt == QCNT_W'(QDEPTH));
  assign empty = (cnt == '0);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      cnt <= cnt + QCNT_W'(1);
      else if (pop && !push) cnt <= cnt - QCNT_W'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

endmodule

[design/rdta_back.sv]
// ----------------------------------------------------------------------------
// rdta_back
// Holds the two-bank digit store and plays a finished conversion back most
// significant digit first, one character per beat, through the digit table.
// ----------------------------------------------------------------------------
module rdta_back import rdta_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  store_wr_t           store_wr,
  input  q_entry_t            head,
  input  logic                q_empty,
  output logic                pop,
  input  logic [CHARS_W-1:0]  digit_chars_low,
  input  logic [CHARS_W-1:0]  digit_chars_high,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [CHAR_W-1:0]   character,
  output logic                last,
  output logic [COUNT_W-1:0]  digits_total
);

  localparam int MEM_DEPTH = 2 * STORE_DEPTH;

  bk_state_t state, state_next;

  logic [DIGIT_W-1:0] mem [MEM_DEPTH];
  logic [DIGIT_W-1:0] rd_data;
  logic [IDX_W-1:0]   pos;
  logic               bank;
  logic [COUNT_W-1:0] total;

  logic               rd_en;
  logic [IDX_W:0]     rd_addr;
  logic [IDX_W-1:0]   head_last_idx;
  logic [IDX_W-1:0]   pos_dec;
  logic [COUNT_W-1:0] head_count_dec;
  logic [CHARS_W-1:0] chars_sel;

  assign head_count_dec = head.count - COUNT_W'(1);
  assign head_last_idx  = head_count_dec[IDX_W-1:0];
  assign pos_dec        = pos - IDX_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) state_next = BK_SEND;
      end
      BK_SEND: begin
        if (m_tready && pos == '0) state_next = BK_IDLE;
      end
    endcase
  end

  // Outputs and store read requests
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = {bank, pos_dec};
    pop      = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          rd_en   = 1'b1;
          rd_addr = {head.bank, head_last_idx};
        end
      end
      BK_SEND: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (pos == '0) pop = 1'b1;
          else           rd_en = 1'b1;
        end
      end
    endcase
  end

  // Character lookup from the registered digit
  assign chars_sel    = rd_data[DIGIT_W-1] ? digit_chars_high : digit_chars_low;
  assign character    = chars_sel[{rd_data[DIGIT_W-2:0], 3'b000} +: CHAR_W];
  assign last         = (pos == '0);
  assign digits_total = total;

  // Control
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Run position
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && !q_empty) begin
      pos   <= head_last_idx;
      bank  <= head.bank;
      total <= head.count;
    end else if (state == BK_SEND && m_tready && pos != '0) begin
      pos <= pos_dec;
    end
  end

  // Digit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_wr.en) mem[store_wr.addr] <= store_wr.digit;
    if (rd_en)       rd_data <= mem[rd_addr];
  end

endmodule

[design/radix_digits_to_ascii.sv]
// ----------------------------------------------------------------------------
// radix_digits_to_ascii
// Unsigned value to text in a configurable radix, one character per beat.
//
//   channel  dir  signals                         content
//   s_*      in   s_tvalid s_tready s_tdata[63:0] value
//   m_*      out  m_tvalid m_tready m_tdata m_tlast character, count, last
//   cfg_*    in   cfg_valid cfg_ready cfg_index cfg_data   register writes
//
// Conversion runs one 8-step slice of the shared divider per cycle, digit
// by digit. Emission then runs one character per cycle from the digit
// store while m_tready is high.
// Both halves overlap through a two-entry queue and a two-bank store.
// Reset is synchronous; the digit store needs no clearing pass.
// Output stalls hold the back only; the front keeps converting until the
// queue is full.
// ----------------------------------------------------------------------------
`include "radix_digits_to_ascii_assert.svh"

module radix_digits_to_ascii import rdta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // beats in: value
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [VALUE_W-1:0]   s_tdata,   // [63:0] value
  // beats out: one per character
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [7:0] character, [14:8] digits_total, [15] zero
  output logic                 m_tlast,   // last
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHARS_W-1:0]   cfg_data
);

  logic [RADIX_W-1:0]  radix;
  logic [CHARS_W-1:0]  digit_chars_low;
  logic [CHARS_W-1:0]  digit_chars_high;
  logic [RADIX_W-1:0]  eff_radix;

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  q_entry_t            q_in;
  q_entry_t            q_head;
  store_wr_t           store_wr;

  logic [CHAR_W-1:0]   character;
  logic [COUNT_W-1:0]  digits_total;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix            <= RADIX_RESET;
      digit_chars_low  <= CHARS_LOW_RESET;
      digit_chars_high <= CHARS_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX:      radix            <= cfg_data[RADIX_W-1:0];
        CFG_CHARS_LOW:  digit_chars_low  <= cfg_data;
        CFG_CHARS_HIGH: digit_chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Radix saturates into 2..MAX_RADIX
  always_comb begin
    if (radix < RADIX_W'(2))              eff_radix = RADIX_W'(2);
    else if (radix > RADIX_W'(MAX_RADIX)) eff_radix = RADIX_W'(MAX_RADIX);
    else                                  eff_radix = radix;
  end

  rdta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .radix      (eff_radix),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in),
    .store_wr   (store_wr)
  );

  rdta_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  rdta_back u_back (
    .clk              (clk),
    .rst              (rst),
    .store_wr         (store_wr),
    .head             (q_head),
    .q_empty          (q_empty),
    .pop              (q_pop),
    .digit_chars_low  (digit_chars_low),
    .digit_chars_high (digit_chars_high),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .character        (character),
    .last             (m_tlast),
    .digits_total     (digits_total)
  );

  // Output beat packing
  assign m_tdata = {1'b0, digits_total, character};

  // Checks
  `RDTA_ASSERT_NOW(a_push_not_full, clk, rst, q_push, !q_full)
  `RDTA_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `RDTA_ASSERT_NEXT(a_run_no_gap, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid)
  `RDTA_ASSERT_NOW(a_total_nonzero, clk, rst, m_tvalid, digits_total != '0)

endmodule

[sim/radix_digits_to_ascii_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_digits_to_ascii_tb
// Self-checking bench for the radix digit converter. Values go in on the
// slave stream, characters come back one beat each on the master stream.
// A predictor keeps its own copy of radix and digit table, turns each
// accepted value into the expected character beats and checks every beat
// in order. A short directed script with typed-in text runs first, then
// random phases with new settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module radix_digits_to_ascii_tb;
  import rdta_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 600;     // longest conversion plus emission
  localparam int TEXT_MAX      = 20;      // longest typed-in text, in chars
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 24;
  localparam int PRINT_CAP     = 100;     // keep the log short on a bad run

  // Index no register answers to
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] { ROW_WRITE, ROW_VALUE } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     index;
    logic [63:0]              data;
    logic [8*TEXT_MAX-1:0]    text;   // zero: use the predictor
  } script_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [COUNT_W-1:0] total;
  } char_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [VALUE_W-1:0]   s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CHARS_W-1:0]   cfg_data = '0;

  // Shadow of the register file
  logic [RADIX_W-1:0]   radix_shadow    = RADIX_RESET;
  logic [CHARS_W-1:0]   chars_lo_shadow = CHARS_LOW_RESET;
  logic [CHARS_W-1:0]   chars_hi_shadow = CHARS_HIGH_RESET;

  char_beat_t  pending_chars[$];
  script_row_t script[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          source_gaps = 1'b1;
  bit          sink_stalls = 1'b1;

  radix_digits_to_ascii uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Radix actually used: saturates to 2..MAX_RADIX
  function automatic int unsigned effective_radix();
    int unsigned r;
    r = 32'(radix_shadow);
    if (r < 2) r = 2;
    if (r > MAX_RADIX) r = MAX_RADIX;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d[3]) return chars_hi_shadow[8*d[2:0] +: 8];
    return chars_lo_shadow[8*d[2:0] +: 8];
  endfunction

  // Predictor: digits of one value, most significant first
  function automatic void convert_value(input logic [VALUE_W-1:0] v);
    logic [DIGIT_W-1:0] digits [STORE_DEPTH];
    longint unsigned    rest;
    int unsigned        r;
    int unsigned        n;
    char_beat_t         b;
    r = effective_radix();
    rest = v;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(rest % r);
      rest = rest / r;
      n++;
    end while (rest != 0 && n < STORE_DEPTH);
    for (int k = 0; k < n; k++) begin
      b.character = digit_char(digits[n-1-k]);
      b.last      = (k == n - 1);
      b.total     = COUNT_W'(n);
      pending_chars.push_back(b);
    end
  endfunction

  // Typed-in text: first character in the highest used byte
  function automatic void queue_text(input logic [8*TEXT_MAX-1:0] text);
    int         n;
    char_beat_t b;
    n = 0;
    while (n < TEXT_MAX && text[8*n +: 8] != 8'h00) n++;
    for (int k = 0; k < n; k++) begin
      b.character = text[8*(n-1-k) +: 8];
      b.last      = (k == n - 1);
      b.total     = COUNT_W'(n);
      pending_chars.push_back(b);
    end
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [CFG_IDX_W-1:0] index,
                                  input logic [63:0] data, input logic [8*TEXT_MAX-1:0] text);
    script_row_t row;
    row.kind  = kind;
    row.index = index;
    row.data  = data;
    row.text  = text;
    script.push_back(row);
  endfunction

  // Random value: zero, all ones, full width, short, or near a radix power
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    longint unsigned    p;
    int unsigned        r;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2, 3: ;
      4, 5: begin
        r = effective_radix();
        p = 1;
        repeat ($urandom_range(1, 64))
          if (p <= 64'hFFFF_FFFF_FFFF_FFFF / r) p = p * r;
        v = $urandom_range(0, 1) ? p : p - 1;
      end
      default: v = v >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  // One value beat; the prediction is queued at acceptance
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic [8*TEXT_MAX-1:0] text);
    int unsigned gap;
    gap = source_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    if (text != '0) queue_text(text);
    else convert_value(v);
  endtask

  // Hold the source until every pending character has come back
  task automatic drain_output();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_RADIX:      radix_shadow    = data[RADIX_W-1:0];
      CFG_CHARS_LOW:  chars_lo_shadow = data;
      CFG_CHARS_HIGH: chars_hi_shadow = data;
      default: ;      // no register, write dropped
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Sink: random stall before each beat
  initial begin
    int unsigned stall;
    forever begin
      stall = sink_stalls ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Beat checker
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
          $display("%0t: unexpected beat, expected none, got tdata %h tlast %b",
                   $time, m_tdata, m_tlast);
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata[7:0] !== want.character) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: character expected %h got %h", $time, want.character, m_tdata[7:0]);
        end
        if (m_tdata[15:8] !== {1'b0, want.total}) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: digits_total expected %h got %h", $time, {1'b0, want.total},
                     m_tdata[15:8]);
        end
        if (m_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: last expected %b got %b", $time, want.last, m_tlast);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("radix_digits_to_ascii_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [RADIX_W-1:0] radix_pick;

    // Directed script: reset settings, radix extremes, saturation, tables
    add_row(ROW_VALUE, CFG_RADIX, 64'd0, "0");
    add_row(ROW_VALUE, CFG_RADIX, 64'd9, "9");
    add_row(ROW_VALUE, CFG_RADIX, 64'd10, "10");
    add_row(ROW_VALUE, CFG_RADIX, 64'd255, "255");
    add_row(ROW_VALUE, CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615");
    add_row(ROW_VALUE, CFG_RADIX, 64'h8000_0000_0000_0000, "9223372036854775808");
    add_row(ROW_WRITE, CFG_RADIX, 64'd16, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff");
    add_row(ROW_VALUE, CFG_RADIX, 64'h0123_4567_89AB_CDEF, "123456789abcdef");
    add_row(ROW_VALUE, CFG_RADIX, 64'd0, "0");
    add_row(ROW_WRITE, CFG_RADIX, 64'd2, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'd1, "1");
    add_row(ROW_VALUE, CFG_RADIX, 64'd2, "10");
    // radix below two acts as two, above sixteen as sixteen
    add_row(ROW_WRITE, CFG_RADIX, 64'd0, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'd5, "101");
    add_row(ROW_WRITE, CFG_RADIX, 64'd1, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'd6, "110");
    add_row(ROW_WRITE, CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'hAB, "ab");
    add_row(ROW_WRITE, CFG_RADIX, 64'd17, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'hFF, "ff");
    // letters A..P as digit table
    add_row(ROW_WRITE, CFG_CHARS_LOW, 64'h4847_4645_4443_4241, '0);
    add_row(ROW_WRITE, CFG_CHARS_HIGH, 64'h504F_4E4D_4C4B_4A49, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'h0123_4567_89AB_CDEF, "BCDEFGHIJKLMNOP");
    add_row(ROW_VALUE, CFG_RADIX, 64'd0, "A");
    // write to an unused index leaves the table alone
    add_row(ROW_WRITE, CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'hF0, "PA");
    // table extremes
    add_row(ROW_WRITE, CFG_CHARS_LOW, 64'h0, '0);
    add_row(ROW_WRITE, CFG_CHARS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'h80, '0);
    add_row(ROW_WRITE, CFG_RADIX, 64'd3, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    add_row(ROW_WRITE, CFG_RADIX, 64'd7, '0);
    add_row(ROW_VALUE, CFG_RADIX, 64'hDEAD_BEEF_0000_0001, '0);

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        drain_output();
        write_register(script[i].index, script[i].data);
      end else begin
        send_value(script[i].data, script[i].text);
      end
    end

    // Random phases, each with fresh settings and idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_output();
      case ($urandom_range(0, 3))
        0: radix_pick = RADIX_W'($urandom_range(0, 31));
        1: begin
          case ($urandom_range(0, 5))
            0: radix_pick = 5'd0;
            1: radix_pick = 5'd1;
            2: radix_pick = 5'd2;
            3: radix_pick = 5'd16;
            4: radix_pick = 5'd17;
            default: radix_pick = 5'd31;
          endcase
        end
        default: radix_pick = RADIX_W'($urandom_range(2, 16));
      endcase
      // upper data bits are don't-care for the radix register
      write_register(CFG_RADIX, {$urandom, 27'($urandom_range(0, 7)), radix_pick});
      case ($urandom_range(0, 2))
        0: begin
          write_register(CFG_CHARS_LOW, CHARS_LOW_RESET);
          write_register(CFG_CHARS_HIGH, CHARS_HIGH_RESET);
        end
        1: begin
          write_register(CFG_CHARS_LOW, {$urandom, $urandom});
          write_register(CFG_CHARS_HIGH, {$urandom, $urandom});
        end
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
        write_register(CFG_UNUSED, {$urandom, $urandom});
      case ($urandom_range(0, 3))
        0: begin source_gaps = 1'b0; sink_stalls = 1'b0; end
        default: begin
          source_gaps = 1'($urandom_range(0, 1));
          sink_stalls = 1'($urandom_range(0, 1));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_value(pick_value(), '0);
        if ($urandom_range(0, 15) == 0) drain_output();
      end
    end

    drain_output();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("radix_digits_to_ascii_tb: done, clean");
    end else begin
      $display("radix_digits_to_ascii_tb: done, errors");
    end
    $finish;
  end

endmodule
